// File: sv/esbl_pkg.sv
// Shared types and constants for the exit stub branch linker.
package esbl_pkg;

  localparam int unsigned S_TDATA_W = 160;
  localparam int unsigned M_TDATA_W = 136;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ENTRY_W   = 128;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SLOT  = 2'd1,
    KIND_STUB  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // opcode masks and matches of the immediate-loading words
  localparam logic [31:0] MASK_20   = 32'hfe00_0000;
  localparam logic [31:0] MASK_12   = 32'hffc0_0000;
  localparam logic [31:0] OP_LU12I  = 32'h1400_0000;
  localparam logic [31:0] OP_ORI    = 32'h0380_0000;
  localparam logic [31:0] OP_LU32I  = 32'h1600_0000;
  localparam logic [31:0] OP_LU52I  = 32'h0300_0000;

  localparam logic [31:0] PLACEHOLDER_WORD = 32'h5000_0400;
  localparam logic [31:0] B_OPCODE         = 32'h5000_0000;

  typedef struct packed {
    logic        absorb;
    logic [63:0] imm;
  } stub_dec_t;

  typedef struct packed {
    logic hit;
    logic more;
  } step_stat_t;

endpackage

// File: sv/esbl_ram.sv
// Generic single-port RAM with registered read.
module esbl_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/esbl_stub_dec.sv
// Decoder for exit stub words: spots immediate loads and places their bits.
module esbl_stub_dec import esbl_pkg::*; (
  input  logic [31:0] word,
  output stub_dec_t   dec
);

  always_comb begin
    dec.absorb = 1'b1;
    dec.imm    = '0;
    priority if ((word & MASK_20) == OP_LU12I) begin
      dec.imm[31:12] = word[24:5];
    end else if ((word & MASK_12) == OP_ORI) begin
      dec.imm[11:0] = word[21:10];
    end else if ((word & MASK_20) == OP_LU32I) begin
      dec.imm[51:32] = word[24:5];
    end else if ((word & MASK_12) == OP_LU52I) begin
      dec.imm[63:52] = word[21:10];
    end else begin
      dec.absorb = 1'b0;
    end
  end

endmodule

// File: sv/esbl_search_step.sv
// One binary search step: compares the probed entry and narrows the bounds.
module esbl_search_step import esbl_pkg::*; #(
  parameter int unsigned CW = 11
) (
  input  logic [CW-1:0] lo,
  input  logic [CW-1:0] hi,
  input  logic [CW-1:0] mid,
  input  logic [63:0]   key,
  input  logic [63:0]   entry_pc,
  output logic [CW-1:0] lo_next,
  output logic [CW-1:0] hi_next,
  output logic [CW-1:0] mid_next,
  output step_stat_t    stat
);

  logic gt;

  always_comb begin
    stat.hit = (key == entry_pc);
    gt       = (key > entry_pc);
    lo_next  = gt ? mid + CW'(1) : lo;
    hi_next  = (!stat.hit && !gt) ? mid : hi;
    stat.more = !stat.hit && (lo_next < hi_next);
    mid_next = lo_next + ((hi_next - lo_next) >> 1);
  end

endmodule

// File: sv/exit_stub_branch_linker_top.sv
// Top level of the exit stub branch linker: request handling and search sequencer.
//
// Input channel s_*: one request per handshake, kind on s_tuser.
//   kind 0 appends (guest_pc, host_addr) to the block table (ignored when full),
//   kind 1 opens a link slot (address, original word) and clears the PC
//   accumulator, kind 2 feeds an exit stub word, kind 3 empties the table.
// Output channel m_*: one patched branch per closed stub.
// Sequencing: every request except a stub-closing word leaves the block
//   ready again on the next cycle. A stub-closing word runs S search
//   probes in ST_SEARCH, S at most ceil(log2(entries + 1)) (11 for a full
//   1024-entry table, 0 when empty), then ST_OFFSET and ST_EMIT. The single
//   table RAM port paces this: one probe read per cycle, one more read for
//   the load address.
// The result sits in an output register; a new request is taken while it
//   waits. A stalled receiver only holds the sequencer in its final step
//   once the next result is ready.
// Reset clears the entry count, accumulator, slot state and output valid.
//   Table contents are not cleared; entries at or above the count are never
//   used.
module exit_stub_branch_linker_top import esbl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: guest_pc[63:0], host_addr[127:64], inst_word[159:128]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // s_tuser: kind[1:0]
  input  logic [KIND_W-1:0]    s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: patched_word[31:0], fixup_offset[63:32], target_pc[127:64],
  //          exact_match[128], past_table[129], placeholder_ok[130], zero[135:131]
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_OFFSET = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t state;

  // architectural state
  logic [CW-1:0] count;
  logic [63:0]   acc;
  logic [63:0]   slot;
  logic          ph_ok;
  logic          active;

  // search working registers
  logic [CW-1:0] lo, hi, mid, idx;
  logic          exact;
  logic          past;
  logic [31:0]   off;

  // request fields
  logic [1:0]  kind;
  logic [63:0] in_gpc, in_haddr;
  logic [31:0] in_word;
  assign kind     = s_tuser;
  assign in_gpc   = s_tdata[63:0];
  assign in_haddr = s_tdata[127:64];
  assign in_word  = s_tdata[159:128];

  logic accept, full, load_we, stub_end;
  stub_dec_t dec;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CW'(TABLE_DEPTH));
  assign load_we  = accept && (kind == KIND_LOAD) && !full;
  assign stub_end = accept && (kind == KIND_STUB) && active && !dec.absorb;

  esbl_stub_dec u_dec (
    .word (in_word),
    .dec  (dec)
  );

  // table RAM: entry pc in the low half, load address in the high half
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [CW-1:0]      start_mid, fin_idx;

  esbl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .addr  (ram_addr),
    .wdata ({in_haddr, in_gpc}),
    .rdata (ram_rdata)
  );

  // shared compare/step unit, used once per probe
  logic [CW-1:0] lo_next, hi_next, mid_next;
  step_stat_t    stat;

  esbl_search_step #(
    .CW (CW)
  ) u_step (
    .lo       (lo),
    .hi       (hi),
    .mid      (mid),
    .key      (acc),
    .entry_pc (ram_rdata[63:0]),
    .lo_next  (lo_next),
    .hi_next  (hi_next),
    .mid_next (mid_next),
    .stat     (stat)
  );

  assign start_mid = count >> 1;
  assign fin_idx   = stat.hit ? mid : lo_next;

  // next probe is issued in the same cycle the current one is compared
  always_comb begin
    unique case (state)
      ST_IDLE:   ram_addr = load_we ? count[AW-1:0] : start_mid[AW-1:0];
      ST_SEARCH: ram_addr = stat.more ? mid_next[AW-1:0] : fin_idx[AW-1:0];
      default:   ram_addr = idx[AW-1:0];
    endcase
  end

  logic        past_now;
  logic [63:0] diff;
  logic        out_free;
  assign past_now = (idx >= count);
  assign diff     = ram_rdata[127:64] - slot;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      acc      <= '0;
      slot     <= '0;
      ph_ok    <= 1'b0;
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result replaces the one being taken in the same cycle
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_LOAD: begin
                if (!full) begin
                  count <= count + CW'(1);
                end
              end
              KIND_CLEAR: begin
                count <= '0;
              end
              KIND_SLOT: begin
                slot   <= in_haddr;
                ph_ok  <= (in_word == PLACEHOLDER_WORD);
                acc    <= '0;
                active <= 1'b1;
              end
              default: begin
                if (active) begin
                  if (dec.absorb) begin
                    acc <= acc | dec.imm;
                  end else begin
                    active <= 1'b0;
                  end
                end
              end
            endcase
            if (stub_end) begin
              lo    <= '0;
              hi    <= count;
              mid   <= start_mid;
              exact <= 1'b0;
              idx   <= '0;
              state <= (count == '0) ? ST_OFFSET : ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= mid_next;
          if (!stat.more) begin
            exact <= stat.hit;
            idx   <= fin_idx;
            state <= ST_OFFSET;
          end
        end
        ST_OFFSET: begin
          past  <= past_now;
          off   <= past_now ? 32'd0 : diff[33:2];
          state <= ST_EMIT;
        end
        default: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // output payload register, loaded as the result is handed over
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {5'd0, ph_ok, past, exact, acc, off,
                  B_OPCODE | {6'd0, off[15:0], off[25:16]}};
    end
  end

endmodule

// File: sv/esbl_checker.sv
// Port-level checker for the exit stub branch linker, bound to the top level.
module esbl_checker import esbl_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [KIND_W-1:0]    s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a result left untaken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output result changed while stalled");

  // table and slot requests leave the block ready on the next cycle
  a_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == KIND_LOAD || s_tuser == KIND_SLOT || s_tuser == KIND_CLEAR)
    |=> s_tready)
    else $error("non-stub request did not return to ready");

  // branch encoding agrees with the offset; past the table means no offset and no exact match
  a_enc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:26] == B_OPCODE[31:26] &&
      m_tdata[25:10] == m_tdata[47:32] && m_tdata[9:0] == m_tdata[57:48] &&
      (!m_tdata[129] || (m_tdata[63:32] == 32'd0 && !m_tdata[128])))
    else $error("patched word inconsistent with offset or flags");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind exit_stub_branch_linker_top esbl_checker u_esbl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
